/* src/tvws_pkg.sv */
// Shared types, constants and the sine table for the two-voice wavetable sequencer.
`default_nettype none

package tvws_pkg;

    localparam int SCORE_DEPTH = 256;
    localparam int SCORE_AW    = $clog2(2 * SCORE_DEPTH);

    localparam int KIND_W   = 3;
    localparam int INDEX_W  = 8;
    localparam int PITCH_W  = 16;
    localparam int DUR_W    = 16;
    localparam int SCORE_W  = PITCH_W + DUR_W;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 16;
    localparam int PHASE_W  = 5;
    localparam int LEVEL_W  = 11;
    localparam int DAC_W    = 12;
    localparam int VOL_W    = 8;

    localparam int DIV_STEPS = DAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [LEVEL_W-1:0] LEVEL_MID = LEVEL_W'(1024);
    localparam logic [VOL_W-1:0]   VOL_RESET = VOL_W'(1);

    localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOP   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TICK_A = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK_B = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BEAT   = 3'd5;

    localparam logic VOICE_A = 1'b0;
    localparam logic VOICE_B = 1'b1;

    typedef struct packed {
        logic                start;
        logic [DAC_W-1:0]    dividend;
        logic [VOL_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DAC_W-1:0]    quotient;
    } div_rsp_t;

    function automatic logic [SCORE_AW-1:0] score_addr(input logic v,
                                                       input logic [POS_W-1:0] pos);
        logic [SCORE_AW-1:0] base;
        logic [SCORE_AW-1:0] offs;
        base = v ? SCORE_AW'(SCORE_DEPTH) : '0;
        offs = SCORE_AW'(pos % SCORE_DEPTH);
        return base + offs;
    endfunction

    function automatic logic [LEVEL_W-1:0] sine_level(input logic [PHASE_W-1:0] ph);
        logic [LEVEL_W-1:0] lvl;
        case (ph)
            5'd0:    lvl = 11'd1024;
            5'd1:    lvl = 11'd1200;
            5'd2:    lvl = 11'd1368;
            5'd3:    lvl = 11'd1524;
            5'd4:    lvl = 11'd1660;
            5'd5:    lvl = 11'd1772;
            5'd6:    lvl = 11'd1855;
            5'd7:    lvl = 11'd1907;
            5'd8:    lvl = 11'd1924;
            5'd9:    lvl = 11'd1907;
            5'd10:   lvl = 11'd1855;
            5'd11:   lvl = 11'd1772;
            5'd12:   lvl = 11'd1660;
            5'd13:   lvl = 11'd1524;
            5'd14:   lvl = 11'd1368;
            5'd15:   lvl = 11'd1200;
            5'd16:   lvl = 11'd1024;
            5'd17:   lvl = 11'd848;
            5'd18:   lvl = 11'd680;
            5'd19:   lvl = 11'd524;
            5'd20:   lvl = 11'd388;
            5'd21:   lvl = 11'd276;
            5'd22:   lvl = 11'd193;
            5'd23:   lvl = 11'd141;
            5'd24:   lvl = 11'd124;
            5'd25:   lvl = 11'd141;
            5'd26:   lvl = 11'd193;
            5'd27:   lvl = 11'd276;
            5'd28:   lvl = 11'd388;
            5'd29:   lvl = 11'd524;
            5'd30:   lvl = 11'd680;
            default: lvl = 11'd848;
        endcase
        return lvl;
    endfunction

endpackage

`default_nettype wire

/* src/tvws_if.sv */
// Item, result and configuration channel interfaces of the sequencer.
`default_nettype none

interface tvws_item_if;
    logic                            valid;
    logic                            ready;
    logic [tvws_pkg::KIND_W-1:0]     kind;
    logic                            voice;
    logic [tvws_pkg::INDEX_W-1:0]    entry_index;
    logic [tvws_pkg::PITCH_W-1:0]    entry_pitch;
    logic [tvws_pkg::DUR_W-1:0]      entry_duration;

    modport source (
        output valid, kind, voice, entry_index, entry_pitch, entry_duration,
        input  ready
    );
    modport sink (
        input  valid, kind, voice, entry_index, entry_pitch, entry_duration,
        output ready
    );
endinterface

interface tvws_result_if;
    logic                            valid;
    logic                            ready;
    logic [tvws_pkg::DAC_W-1:0]      dac_value;
    logic [tvws_pkg::PITCH_W-1:0]    period_a;
    logic [tvws_pkg::PITCH_W-1:0]    period_b;
    logic                            playing;
    logic                            song_ended;

    modport source (
        output valid, dac_value, period_a, period_b, playing, song_ended,
        input  ready
    );
    modport sink (
        input  valid, dac_value, period_a, period_b, playing, song_ended,
        output ready
    );
endinterface

interface tvws_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tvws_pkg::VOL_W-1:0]      data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

`default_nettype wire

/* src/tvws_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tvws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

/* src/tvws_div.sv */
// Iterative restoring divider for the mix level, one quotient bit per cycle.
`default_nettype none

module tvws_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tvws_pkg::div_req_t req,
    output      tvws_pkg::div_rsp_t rsp
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [tvws_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [tvws_pkg::DAC_W-1:0]        quo_reg;
    logic [tvws_pkg::VOL_W-1:0]        rem_reg;
    logic [tvws_pkg::VOL_W-1:0]        dvs_reg;

    logic [tvws_pkg::VOL_W:0]          shifted;
    logic [tvws_pkg::VOL_W:0]          diff;
    logic                              ge;

    assign shifted = {rem_reg, quo_reg[tvws_pkg::DAC_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= tvws_pkg::DIV_CNT_W'(tvws_pkg::DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == tvws_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            // a zero divisor divides as one
            dvs_reg <= (req.divisor == '0) ? tvws_pkg::VOL_W'(1) : req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[tvws_pkg::DAC_W-2:0], ge};
            rem_reg <= ge ? diff[tvws_pkg::VOL_W-1:0] : shifted[tvws_pkg::VOL_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

/* src/two_voice_wavetable_sequencer_core.sv */
// Top level of the two-voice wavetable sequencer: control sequencer, voice state, score RAM.
//
// One item is processed at a time; item.ready is high only while the sequencer is idle.
// Every item produces one result. A beat takes longest when both voices move to a new
// note. The time an item takes is set by the 12-step one-bit-per-cycle divider that
// scales the mix, and by the single registered read port of the score RAM, which a beat
// visits up to six times. A finished result waits in an output register, so the next
// item is accepted while it is pending; that item's result then waits until the held one
// is taken. No clearing pass after reset: score entries are undefined until loaded. The
// volume register may be written at any time the block is idle.
`default_nettype none

module two_voice_wavetable_sequencer_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    tvws_item_if.sink         item,
    tvws_result_if.source     result,
    tvws_cfg_if.sink          cfg
);

    localparam int STATE_W = 5;

    localparam logic [STATE_W-1:0] S_IDLE   = 5'd0;
    localparam logic [STATE_W-1:0] S_WR     = 5'd1;
    localparam logic [STATE_W-1:0] S_ST_A   = 5'd2;
    localparam logic [STATE_W-1:0] S_ST_B   = 5'd3;
    localparam logic [STATE_W-1:0] S_ST_END = 5'd4;
    localparam logic [STATE_W-1:0] S_TK_RD  = 5'd5;
    localparam logic [STATE_W-1:0] S_TK_UPD = 5'd6;
    localparam logic [STATE_W-1:0] S_BT_LEN = 5'd7;
    localparam logic [STATE_W-1:0] S_BT_CMP = 5'd8;
    localparam logic [STATE_W-1:0] S_BT_PIT = 5'd9;
    localparam logic [STATE_W-1:0] S_BT_SET = 5'd10;
    localparam logic [STATE_W-1:0] S_END_A  = 5'd11;
    localparam logic [STATE_W-1:0] S_END_B  = 5'd12;
    localparam logic [STATE_W-1:0] S_END_C  = 5'd13;
    localparam logic [STATE_W-1:0] S_DIV    = 5'd14;
    localparam logic [STATE_W-1:0] S_DIVW   = 5'd15;
    localparam logic [STATE_W-1:0] S_PUSH   = 5'd16;

    logic [STATE_W-1:0]                state_reg, state_next;

    logic [tvws_pkg::VOL_W-1:0]        vol_reg;
    logic                              run_reg;
    logic                              vsel_reg;
    logic                              ended_reg;
    logic                              end_a_zero_reg;
    logic [tvws_pkg::POS_W-1:0]        pos_reg    [2];
    logic [tvws_pkg::COUNT_W-1:0]      count_reg  [2];
    logic [tvws_pkg::PHASE_W-1:0]      phase_reg  [2];
    logic [tvws_pkg::LEVEL_W-1:0]      level_reg  [2];
    logic [tvws_pkg::PITCH_W-1:0]      period_reg [2];

    logic                              voice_reg;
    logic [tvws_pkg::INDEX_W-1:0]      index_reg;
    logic [tvws_pkg::PITCH_W-1:0]      pitch_reg;
    logic [tvws_pkg::DUR_W-1:0]        dur_reg;

    logic                              out_valid_reg;
    logic [tvws_pkg::DAC_W-1:0]        out_dac_reg;
    logic [tvws_pkg::PITCH_W-1:0]      out_pa_reg;
    logic [tvws_pkg::PITCH_W-1:0]      out_pb_reg;
    logic                              out_play_reg;
    logic                              out_end_reg;

    logic                              accept;
    logic                              push;
    logic                              ram_we;
    logic [tvws_pkg::SCORE_AW-1:0]     ram_waddr;
    logic [tvws_pkg::SCORE_AW-1:0]     ram_raddr;
    logic [tvws_pkg::SCORE_W-1:0]      ram_wdata;
    logic [tvws_pkg::SCORE_W-1:0]      ram_rdata;
    logic [tvws_pkg::PITCH_W-1:0]      rd_pitch;
    logic [tvws_pkg::DUR_W-1:0]        rd_len;
    logic [tvws_pkg::PHASE_W-1:0]      phase_inc;
    logic                              len_hit;

    tvws_pkg::div_req_t                div_req;
    tvws_pkg::div_rsp_t                div_rsp;

    assign accept    = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign push      = (state_reg == S_PUSH) && (!out_valid_reg || result.ready);

    assign rd_pitch  = ram_rdata[tvws_pkg::SCORE_W-1:tvws_pkg::DUR_W];
    assign rd_len    = ram_rdata[tvws_pkg::DUR_W-1:0];
    assign phase_inc = phase_reg[vsel_reg] + 1'b1;
    assign len_hit   = (rd_len <= count_reg[vsel_reg]);

    assign ram_waddr = tvws_pkg::score_addr(voice_reg, index_reg);
    assign ram_wdata = {pitch_reg, dur_reg};

    tvws_ram #(
        .WIDTH (tvws_pkg::SCORE_W),
        .DEPTH (2 * tvws_pkg::SCORE_DEPTH)
    ) u_score_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign div_req.start    = (state_reg == S_DIV);
    assign div_req.dividend = tvws_pkg::DAC_W'(level_reg[0]) + tvws_pkg::DAC_W'(level_reg[1]);
    assign div_req.divisor  = vol_reg;

    tvws_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_raddr = tvws_pkg::score_addr(vsel_reg, pos_reg[vsel_reg]);
        unique case (state_reg)
            S_WR:    ram_we    = 1'b1;
            S_ST_A:  ram_raddr = tvws_pkg::score_addr(tvws_pkg::VOICE_A, '0);
            S_ST_B:  ram_raddr = tvws_pkg::score_addr(tvws_pkg::VOICE_B, '0);
            S_END_A: ram_raddr = tvws_pkg::score_addr(tvws_pkg::VOICE_A, pos_reg[0]);
            S_END_B: ram_raddr = tvws_pkg::score_addr(tvws_pkg::VOICE_B, pos_reg[1]);
            default: ram_we    = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.kind) inside
                        tvws_pkg::KIND_LOAD:  state_next = S_WR;
                        tvws_pkg::KIND_START: state_next = S_ST_A;
                        tvws_pkg::KIND_TICK_A,
                        tvws_pkg::KIND_TICK_B: state_next = run_reg ? S_TK_RD : S_DIV;
                        tvws_pkg::KIND_BEAT:  state_next = run_reg ? S_BT_LEN : S_DIV;
                        default:              state_next = S_DIV;
                    endcase
                end
            end
            S_WR:     state_next = S_DIV;
            S_ST_A:   state_next = S_ST_B;
            S_ST_B:   state_next = S_ST_END;
            S_ST_END: state_next = S_DIV;
            S_TK_RD:  state_next = S_TK_UPD;
            S_TK_UPD: state_next = S_DIV;
            S_BT_LEN: state_next = S_BT_CMP;
            S_BT_CMP:
            begin
                if (len_hit)
                begin
                    state_next = S_BT_PIT;
                end
                else
                begin
                    state_next = vsel_reg ? S_END_A : S_BT_LEN;
                end
            end
            S_BT_PIT: state_next = S_BT_SET;
            S_BT_SET: state_next = vsel_reg ? S_END_A : S_BT_LEN;
            S_END_A:  state_next = S_END_B;
            S_END_B:  state_next = S_END_C;
            S_END_C:  state_next = S_DIV;
            S_DIV:    state_next = S_DIVW;
            S_DIVW:   state_next = div_rsp.done ? S_PUSH : S_DIVW;
            S_PUSH:   state_next = push ? S_IDLE : S_PUSH;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vol_reg        <= tvws_pkg::VOL_RESET;
            run_reg        <= 1'b0;
            vsel_reg       <= 1'b0;
            ended_reg      <= 1'b0;
            end_a_zero_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int v = 0; v < 2; v++)
            begin
                pos_reg[v]    <= '0;
                count_reg[v]  <= '0;
                phase_reg[v]  <= '0;
                level_reg[v]  <= '0;
                period_reg[v] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                vol_reg <= cfg.data;
            end

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.valid && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ended_reg <= 1'b0;
                        vsel_reg  <= (item.kind == tvws_pkg::KIND_TICK_B);
                        if (item.kind == tvws_pkg::KIND_STOP)
                        begin
                            run_reg       <= 1'b0;
                            pos_reg[0]    <= '0;
                            pos_reg[1]    <= '0;
                            period_reg[0] <= '0;
                            period_reg[1] <= '0;
                        end
                    end
                end
                S_ST_B:
                begin
                    period_reg[0] <= rd_pitch;
                end
                S_ST_END:
                begin
                    period_reg[1] <= rd_pitch;
                    pos_reg[0]    <= '0;
                    pos_reg[1]    <= '0;
                    run_reg       <= 1'b1;
                end
                S_TK_UPD:
                begin
                    // rest holds the midpoint level
                    if (!(rd_pitch == '0 && level_reg[vsel_reg] == tvws_pkg::LEVEL_MID))
                    begin
                        phase_reg[vsel_reg] <= phase_inc;
                        level_reg[vsel_reg] <= tvws_pkg::sine_level(phase_inc);
                    end
                end
                S_BT_LEN:
                begin
                    count_reg[vsel_reg] <= count_reg[vsel_reg] + 1'b1;
                end
                S_BT_CMP:
                begin
                    if (len_hit)
                    begin
                        count_reg[vsel_reg] <= '0;
                        pos_reg[vsel_reg]   <= pos_reg[vsel_reg] + 1'b1;
                    end
                    else
                    begin
                        vsel_reg <= 1'b1;
                    end
                end
                S_BT_SET:
                begin
                    period_reg[vsel_reg] <= rd_pitch;
                    level_reg[vsel_reg]  <= tvws_pkg::LEVEL_MID;
                    vsel_reg             <= 1'b1;
                end
                S_END_B:
                begin
                    end_a_zero_reg <= (rd_len == '0);
                end
                S_END_C:
                begin
                    if (end_a_zero_reg || rd_len == '0)
                    begin
                        run_reg       <= 1'b0;
                        ended_reg     <= 1'b1;
                        pos_reg[0]    <= '0;
                        pos_reg[1]    <= '0;
                        period_reg[0] <= '0;
                        period_reg[1] <= '0;
                    end
                end
                default:
                begin
                    ended_reg <= ended_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            voice_reg <= item.voice;
            index_reg <= item.entry_index;
            pitch_reg <= item.entry_pitch;
            dur_reg   <= item.entry_duration;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_dac_reg  <= div_rsp.quotient;
            out_pa_reg   <= period_reg[0];
            out_pb_reg   <= period_reg[1];
            out_play_reg <= run_reg;
            out_end_reg  <= ended_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.dac_value  = out_dac_reg;
    assign result.period_a   = out_pa_reg;
    assign result.period_b   = out_pb_reg;
    assign result.playing    = out_play_reg;
    assign result.song_ended = out_end_reg;

endmodule

`default_nettype wire

/* src/tvws_checker.sv */
// Port-level checker for the sequencer and its bind to the top level.
`default_nettype none

module tvws_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [tvws_pkg::DAC_W-1:0]    dac_value,
    input wire logic [tvws_pkg::PITCH_W-1:0]  period_a,
    input wire logic [tvws_pkg::PITCH_W-1:0]  period_b,
    input wire logic                          playing,
    input wire logic                          song_ended
);

    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sequencer took a second item while busy");

    a_end_stops_play: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && song_ended |-> !playing)
        else $error("end of score reported while still playing");

    a_stopped_periods: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !playing |-> period_a == '0 && period_b == '0)
        else $error("timer period nonzero while stopped");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
            $stable({dac_value, period_a, period_b, playing, song_ended}))
        else $error("stalled result changed");

endmodule

bind two_voice_wavetable_sequencer_core tvws_checker u_tvws_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .dac_value  (result.dac_value),
    .period_a   (result.period_a),
    .period_b   (result.period_b),
    .playing    (result.playing),
    .song_ended (result.song_ended)
);

`default_nettype wire
